@@ sv/mahalanobis_chroma_classifier_defines.svh @@
// Assertion macros for the chroma classifier.
`ifndef MAHALANOBIS_CHROMA_CLASSIFIER_DEFINES_SVH
`define MAHALANOBIS_CHROMA_CLASSIFIER_DEFINES_SVH
`ifndef ASSERT_OFF
`define MCC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("classifier check failed");
`define MCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("classifier check failed");
`else
`define MCC_ASSERT_IMPLY(label, ante, cons)
`define MCC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ sv/mcc_pkg.sv @@
// Package with types and constants of the chroma classifier.
`timescale 1ns / 1ps
package mcc_pkg;

    localparam int NUM_CLASSES_DEF = 8;
    localparam int COUNT_BITS_DEF  = 16;

    localparam logic [63:0] DET_FLOOR = 64'd28147497;
    localparam logic [31:0] THETA_RESET = 32'd150994944;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    localparam logic REG_THETA  = 1'b0;
    localparam logic REG_ACTIVE = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [2:0]         class_slot;
        logic [15:0]        mean_u_in;
        logic [15:0]        mean_v_in;
        logic signed [31:0] inv_uu_in;
        logic signed [31:0] inv_uv_in;
        logic signed [31:0] inv_vv_in;
        logic [7:0]         chroma_u;
        logic [7:0]         chroma_v;
        logic               last_pixel;
    } mcc_req_t;

    typedef struct packed {
        logic [7:0]  member_mask;
        logic        decision_valid;
        logic        class_found;
        logic [2:0]  class_index;
        logic [15:0] winning_count;
    } mcc_res_t;

    typedef struct packed {
        logic       count_en;
        logic       count_clr;
        logic       load_en;
        logic [2:0] load_slot;
    } mcc_ctl_t;

endpackage

@@ sv/mcc_weight.sv @@
// Determinant magnitude unit that computes a class weight at model load.
`timescale 1ns / 1ps
module mcc_weight (
    input  logic               clk,
    input  logic signed [31:0] inv_uu,
    input  logic signed [31:0] inv_uv,
    input  logic signed [31:0] inv_vv,
    output logic [63:0]        weight
);
    import mcc_pkg::*;

    logic signed [63:0] prod_a_reg;
    logic signed [63:0] prod_b_reg;
    logic signed [64:0] det_reg;
    logic [63:0]        weight_reg;
    logic [64:0]        mag;

    always_comb
    begin
        mag = det_reg[64] ? 65'(-det_reg) : 65'(det_reg);
    end

    always_ff @(posedge clk)
    begin
        prod_a_reg <= inv_uu * inv_vv;
        prod_b_reg <= inv_uv * inv_uv;
        det_reg    <= 65'(prod_a_reg) - 65'(prod_b_reg);
        weight_reg <= (mag[63:0] <= DET_FLOOR) ? 64'd0 : mag[63:0];
    end

    assign weight = weight_reg;

endmodule

@@ sv/mcc_cell.sv @@
// One class cell: holds a class model and count, tests membership and scans for the best.
`timescale 1ns / 1ps
module mcc_cell #(
    parameter int CELL_IDX   = 0,
    parameter int COUNT_BITS = mcc_pkg::COUNT_BITS_DEF,
    parameter int SLOT_BITS  = 3
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mcc_pkg::mcc_ctl_t          ctl,
    input  logic                       active,
    input  logic [7:0]                 pix_u,
    input  logic [7:0]                 pix_v,
    input  logic [31:0]                theta,
    input  logic [15:0]                ld_mean_u,
    input  logic [15:0]                ld_mean_v,
    input  logic signed [31:0]         ld_inv_uu,
    input  logic signed [31:0]         ld_inv_uv,
    input  logic signed [31:0]         ld_inv_vv,
    input  logic [63:0]                ld_weight,
    input  logic [COUNT_BITS+63:0]     best_in_score,
    input  logic                       best_in_found,
    input  logic [SLOT_BITS-1:0]       best_in_slot,
    input  logic [COUNT_BITS-1:0]      best_in_count,
    output logic [COUNT_BITS+63:0]     best_out_score,
    output logic                       best_out_found,
    output logic [SLOT_BITS-1:0]       best_out_slot,
    output logic [COUNT_BITS-1:0]      best_out_count,
    output logic                       member
);
    import mcc_pkg::*;

    localparam int SCORE_BITS = COUNT_BITS + 64;

    logic [15:0]               mean_u_reg;
    logic [15:0]               mean_v_reg;
    logic signed [31:0]        inv_uu_reg;
    logic signed [31:0]        inv_uv_reg;
    logic signed [31:0]        inv_vv_reg;
    logic [63:0]               weight_reg;
    logic [COUNT_BITS-1:0]     count_reg;
    logic [COUNT_BITS-1:0]     count_next;
    logic                      member_reg;
    logic                      member_next;

    logic signed [16:0]        du_reg;
    logic signed [16:0]        dv_reg;
    logic signed [33:0]        pp_uu_reg;
    logic signed [33:0]        pp_uv_reg;
    logic signed [33:0]        pp_vv_reg;
    logic signed [65:0]        t_uu_reg;
    logic signed [65:0]        t_uv_reg;
    logic signed [65:0]        t_vv_reg;
    logic signed [68:0]        q_reg;

    logic [COUNT_BITS+31:0]    p_lo_reg;
    logic [COUNT_BITS+31:0]    p_hi_reg;
    logic [SCORE_BITS-1:0]     score_reg;
    logic                      better;

    logic [SCORE_BITS-1:0]     bscore_reg;
    logic                      bfound_reg;
    logic [SLOT_BITS-1:0]      bslot_reg;
    logic [COUNT_BITS-1:0]     bcount_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load_en && (32'(ctl.load_slot) == CELL_IDX))
        begin
            mean_u_reg <= ld_mean_u;
            mean_v_reg <= ld_mean_v;
            inv_uu_reg <= ld_inv_uu;
            inv_uv_reg <= ld_inv_uv;
            inv_vv_reg <= ld_inv_vv;
            weight_reg <= ld_weight;
        end
    end

    // Distance pipeline: difference, squares, weighted terms, sum.
    always_ff @(posedge clk)
    begin
        du_reg    <= $signed({1'b0, pix_u, 8'd0}) - $signed({1'b0, mean_u_reg});
        dv_reg    <= $signed({1'b0, pix_v, 8'd0}) - $signed({1'b0, mean_v_reg});
        pp_uu_reg <= du_reg * du_reg;
        pp_uv_reg <= du_reg * dv_reg;
        pp_vv_reg <= dv_reg * dv_reg;
        t_uu_reg  <= pp_uu_reg * inv_uu_reg;
        t_uv_reg  <= pp_uv_reg * inv_uv_reg;
        t_vv_reg  <= pp_vv_reg * inv_vv_reg;
        q_reg     <= 69'(t_uu_reg) + (69'(t_uv_reg) <<< 1) + 69'(t_vv_reg);
    end

    always_comb
    begin
        member_next = active && !q_reg[68] && (q_reg[67:48] == 20'd0)
                      && (q_reg[47:0] < {theta, 16'd0});
        count_next = count_reg;
        if (ctl.count_clr)
        begin
            count_next = '0;
        end
        else if (ctl.count_en && member_next && (count_reg != {COUNT_BITS{1'b1}}))
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            member_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (ctl.count_en)
            begin
                member_reg <= member_next;
            end
        end
    end

    // Score is count times weight, built from two 32-bit halves of the weight.
    always_ff @(posedge clk)
    begin
        p_lo_reg  <= count_reg * weight_reg[31:0];
        p_hi_reg  <= count_reg * weight_reg[63:32];
        score_reg <= {p_hi_reg, 32'd0} + SCORE_BITS'(p_lo_reg);
    end

    assign better = active && (score_reg > best_in_score);

    always_ff @(posedge clk)
    begin
        if (better)
        begin
            bscore_reg <= score_reg;
            bfound_reg <= 1'b1;
            bslot_reg  <= SLOT_BITS'(CELL_IDX);
            bcount_reg <= count_reg;
        end
        else
        begin
            bscore_reg <= best_in_score;
            bfound_reg <= best_in_found;
            bslot_reg  <= best_in_slot;
            bcount_reg <= best_in_count;
        end
    end

    assign best_out_score = bscore_reg;
    assign best_out_found = bfound_reg;
    assign best_out_slot  = bslot_reg;
    assign best_out_count = bcount_reg;
    assign member         = member_reg;

endmodule

@@ sv/mahalanobis_chroma_classifier.sv @@
// Top level of the Mahalanobis chroma classifier with its control and register port.
//
//  Port group   Direction  Handshake          Carries
//  req          in         req_valid/ready    load item or pixel item
//  res          out        res_valid/ready    member mask and cluster decision
//  apb          in/out     psel/penable       theta_squared, active_classes
//
// A load item is written to its cell once the weight has passed the
// determinant unit, which is three stages deep. A pixel item waits for
// the cell pipeline to compare its distance; a last pixel also waits for
// the best-score search, which walks the cell chain one cell per cycle.
// One request is in work at a time. A finished result waits in the output
// register while the next request is taken and processed; the block stalls
// only if a new result is ready and the previous one was not yet taken. Reset
// clears the counts and the control state and sets the registers to their
// reset values; class models stay undefined until loaded.
`timescale 1ns / 1ps
`include "mahalanobis_chroma_classifier_defines.svh"
module mahalanobis_chroma_classifier #(
    parameter int NUM_CLASSES = mcc_pkg::NUM_CLASSES_DEF,
    parameter int COUNT_BITS  = mcc_pkg::COUNT_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  mcc_pkg::mcc_req_t req,
    output logic             res_valid,
    input  logic             res_ready,
    output mcc_pkg::mcc_res_t res,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import mcc_pkg::*;

    localparam int SLOT_BITS  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int SCORE_BITS = COUNT_BITS + 64;
    localparam int PIX_STEP   = 5;
    localparam int LAST_STEP  = 7 + NUM_CLASSES;
    localparam int LOAD_STEP  = 3;
    localparam int STEP_BITS  = $clog2(LAST_STEP + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_PIX  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [STEP_BITS-1:0]   step_reg;
    logic [STEP_BITS-1:0]   step_next;
    mcc_req_t               item_reg;
    mcc_res_t               hold_reg;
    mcc_res_t               hold_next;
    mcc_res_t               res_reg;
    logic                   res_valid_reg;
    logic                   res_valid_next;
    logic [31:0]            theta_reg;
    logic [3:0]             active_reg;
    mcc_ctl_t               ctl;
    logic                   req_fire;
    logic                   cfg_write;
    logic [63:0]            weight;
    logic [NUM_CLASSES-1:0] member;
    logic [NUM_CLASSES-1:0] active_vec;
    logic [7:0]             mask;
    logic [31:0]            win_count_ext;
    logic [7:0]             win_slot_ext;

    logic [SCORE_BITS-1:0]  chain_score [NUM_CLASSES+1];
    logic                   chain_found [NUM_CLASSES+1];
    logic [SLOT_BITS-1:0]   chain_slot  [NUM_CLASSES+1];
    logic [COUNT_BITS-1:0]  chain_count [NUM_CLASSES+1];

    // Register port. pready is tied high, so every access completes at once.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            REG_THETA:  prdata = theta_reg;
            REG_ACTIVE: prdata = {28'd0, active_reg};
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            theta_reg  <= THETA_RESET;
            active_reg <= 4'd0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_THETA:  theta_reg  <= pwdata;
                REG_ACTIVE: active_reg <= pwdata[3:0];
                default:    theta_reg  <= theta_reg;
            endcase
        end
    end

    // A request is taken only in idle; its fields are held for the whole work.
    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            item_reg <= req;
        end
    end

    // Slots at or above active_classes sit out; values above NUM_CLASSES
    // simply enable every cell.
    genvar gk;
    generate
        for (gk = 0; gk < NUM_CLASSES; gk++)
        begin : g_active
            assign active_vec[gk] = (32'(active_reg) > gk);
        end
    endgenerate

    // Control sequencer. The step counter times the cell pipeline: counts are
    // updated at the step where the sum is compared, and the chain's answer is
    // read once every cell has seen the settled scores.
    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        hold_next     = hold_reg;
        ctl.count_en  = 1'b0;
        ctl.count_clr = 1'b0;
        ctl.load_en   = 1'b0;
        ctl.load_slot = item_reg.class_slot;
        case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (req_fire)
                begin
                    state_next = (req.mode == MODE_LOAD) ? ST_LOAD : ST_PIX;
                end
            end
            ST_LOAD:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_BITS'(LOAD_STEP))
                begin
                    ctl.load_en = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_PIX:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_BITS'(PIX_STEP - 1))
                begin
                    ctl.count_en = 1'b1;
                end
                if (!item_reg.last_pixel && (step_reg == STEP_BITS'(PIX_STEP)))
                begin
                    hold_next  = '0;
                    hold_next.member_mask = mask;
                    state_next = ST_DONE;
                end
                if (item_reg.last_pixel && (step_reg == STEP_BITS'(LAST_STEP)))
                begin
                    hold_next = '0;
                    hold_next.member_mask    = mask;
                    hold_next.decision_valid = 1'b1;
                    if (chain_found[NUM_CLASSES])
                    begin
                        hold_next.class_found   = 1'b1;
                        hold_next.class_index   = win_slot_ext[2:0];
                        hold_next.winning_count = win_count_ext[15:0];
                    end
                    ctl.count_clr = 1'b1;
                    state_next    = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg && !res_ready;
        if ((state_reg == ST_DONE) && (!res_valid_reg || res_ready))
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        if ((state_reg == ST_DONE) && (!res_valid_reg || res_ready))
        begin
            res_reg <= hold_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Classes beyond the eighth are counted but have no mask bit.
    generate
        for (gk = 0; gk < 8; gk++)
        begin : g_mask
            if (gk < NUM_CLASSES)
            begin : g_on
                assign mask[gk] = member[gk];
            end
            else
            begin : g_off
                assign mask[gk] = 1'b0;
            end
        end
    endgenerate

    assign win_count_ext = 32'(chain_count[NUM_CLASSES]);
    assign win_slot_ext  = 8'(chain_slot[NUM_CLASSES]);

    mcc_weight u_weight (
        .clk    (clk),
        .inv_uu (item_reg.inv_uu_in),
        .inv_uv (item_reg.inv_uv_in),
        .inv_vv (item_reg.inv_vv_in),
        .weight (weight)
    );

    // The chain starts from a zero score so that a winner must be above zero.
    assign chain_score[0] = '0;
    assign chain_found[0] = 1'b0;
    assign chain_slot[0]  = '0;
    assign chain_count[0] = '0;

    generate
        for (gk = 0; gk < NUM_CLASSES; gk++)
        begin : g_cell
            mcc_cell #(
                .CELL_IDX   (gk),
                .COUNT_BITS (COUNT_BITS),
                .SLOT_BITS  (SLOT_BITS)
            ) u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .ctl            (ctl),
                .active         (active_vec[gk]),
                .pix_u          (item_reg.chroma_u),
                .pix_v          (item_reg.chroma_v),
                .theta          (theta_reg),
                .ld_mean_u      (item_reg.mean_u_in),
                .ld_mean_v      (item_reg.mean_v_in),
                .ld_inv_uu      (item_reg.inv_uu_in),
                .ld_inv_uv      (item_reg.inv_uv_in),
                .ld_inv_vv      (item_reg.inv_vv_in),
                .ld_weight      (weight),
                .best_in_score  (chain_score[gk]),
                .best_in_found  (chain_found[gk]),
                .best_in_slot   (chain_slot[gk]),
                .best_in_count  (chain_count[gk]),
                .best_out_score (chain_score[gk+1]),
                .best_out_found (chain_found[gk+1]),
                .best_out_slot  (chain_slot[gk+1]),
                .best_out_count (chain_count[gk+1]),
                .member         (member[gk])
            );
        end
    endgenerate

    `MCC_ASSERT_NEXT(a_one_at_a_time, req_fire, !req_ready)
    `MCC_ASSERT_IMPLY(a_found_needs_decision, res_valid && res.class_found, res.decision_valid)
    `MCC_ASSERT_IMPLY(a_null_is_zero, res_valid && !res.class_found, (res.class_index == 3'd0) && (res.winning_count == 16'd0))
    `MCC_ASSERT_NEXT(a_clear_on_decision, ctl.count_clr, state_reg == ST_DONE)

endmodule

@@ tb/tb_mahalanobis_chroma_classifier.sv @@
// Self-checking testbench of the Mahalanobis chroma classifier.
`timescale 1ns / 1ps
module tb_mahalanobis_chroma_classifier;
    import mcc_pkg::*;

    // Cycles that a load may still be in work once the last pixel result is out.
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_PIXELS   = 80;

    typedef enum logic [1:0] {ROW_REQUEST, ROW_THETA, ROW_ACTIVE} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        mcc_req_t    request;
        logic [31:0] value;
        bit          typed;
        mcc_res_t    typed_res;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    mcc_req_t    req;
    logic        res_valid;
    logic        res_ready;
    mcc_res_t    res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mahalanobis_chroma_classifier dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .res_valid(res_valid), .res_ready(res_ready), .res(res),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Shadow copy of the classifier state, kept in step with accepted requests.
    logic [31:0]        sh_theta;
    logic [3:0]         sh_active;
    logic [15:0]        sh_mean_u [8];
    logic [15:0]        sh_mean_v [8];
    logic signed [31:0] sh_inv_uu [8];
    logic signed [31:0] sh_inv_uv [8];
    logic signed [31:0] sh_inv_vv [8];
    logic [63:0]        sh_weight [8];
    logic [15:0]        sh_count  [8];

    mcc_res_t pending_res [$];
    row_t     stim_rows [$];
    int       mismatches;
    int       idle_max;
    bit       hold_req;

    always #1 clk = ~clk;

    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Does the pixel (u,v) fall within threshold of class k?
    function automatic bit within_class(int k, logic [7:0] u, logic [7:0] v);
        longint du;
        longint dv;
        logic signed [127:0] suu;
        logic signed [127:0] suv;
        logic signed [127:0] svv;
        logic signed [127:0] iuu;
        logic signed [127:0] iuv;
        logic signed [127:0] ivv;
        logic signed [127:0] q;
        logic signed [127:0] limit;
        du = longint'({u, 8'h00}) - longint'(sh_mean_u[k]);
        dv = longint'({v, 8'h00}) - longint'(sh_mean_v[k]);
        suu = du * du;
        suv = du * dv;
        svv = dv * dv;
        iuu = sh_inv_uu[k];
        iuv = sh_inv_uv[k];
        ivv = sh_inv_vv[k];
        q = suu * iuu + 2 * suv * iuv + svv * ivv;
        limit = {80'd0, sh_theta, 16'd0};
        return (q >= 0) && (q < limit);
    endfunction

    // Applies one request to the shadow state; a pixel yields its result.
    function automatic bit classify(mcc_req_t r, output mcc_res_t o);
        int n;
        int best;
        bit found;
        logic [79:0] best_score;
        logic [79:0] score;
        longint det;
        logic [63:0] mag;
        o = '0;
        if (r.mode == MODE_LOAD) begin
            sh_mean_u[r.class_slot] = r.mean_u_in;
            sh_mean_v[r.class_slot] = r.mean_v_in;
            sh_inv_uu[r.class_slot] = r.inv_uu_in;
            sh_inv_uv[r.class_slot] = r.inv_uv_in;
            sh_inv_vv[r.class_slot] = r.inv_vv_in;
            det = longint'(r.inv_uu_in) * longint'(r.inv_vv_in)
                - longint'(r.inv_uv_in) * longint'(r.inv_uv_in);
            mag = det[63] ? -det : det;
            sh_weight[r.class_slot] = (mag <= DET_FLOOR) ? 64'd0 : mag;
            return 0;
        end
        n = (sh_active > 8) ? 8 : sh_active;
        for (int k = 0; k < n; k++) begin
            if (within_class(k, r.chroma_u, r.chroma_v)) begin
                o.member_mask[k] = 1'b1;
                if (sh_count[k] != 16'hFFFF)
                    sh_count[k]++;
            end
        end
        if (r.last_pixel) begin
            best = 0;
            found = 0;
            best_score = '0;
            for (int k = 0; k < n; k++) begin
                score = 80'(sh_count[k]) * 80'(sh_weight[k]);
                if (score > best_score) begin
                    best_score = score;
                    best = k;
                    found = 1;
                end
            end
            o.decision_valid = 1'b1;
            if (found) begin
                o.class_found = 1'b1;
                o.class_index = best[2:0];
                o.winning_count = sh_count[best];
            end
            for (int k = 0; k < 8; k++)
                sh_count[k] = '0;
        end
        return 1;
    endfunction

    function automatic mcc_req_t load_req(int slot, logic [15:0] mu, logic [15:0] mv,
                                          logic [31:0] uu, logic [31:0] uv, logic [31:0] vv);
        mcc_req_t r;
        r = '0;
        r.mode = MODE_LOAD;
        r.class_slot = slot[2:0];
        r.mean_u_in = mu;
        r.mean_v_in = mv;
        r.inv_uu_in = uu;
        r.inv_uv_in = uv;
        r.inv_vv_in = vv;
        return r;
    endfunction

    function automatic mcc_req_t pixel_req(logic [7:0] u, logic [7:0] v, logic last);
        mcc_req_t r;
        r = '0;
        r.mode = MODE_PIXEL;
        r.chroma_u = u;
        r.chroma_v = v;
        r.last_pixel = last;
        return r;
    endfunction

    function automatic void add_row(row_kind_t kind, mcc_req_t r, logic [31:0] value,
                                    bit typed, mcc_res_t e);
        row_t row;
        row.kind = kind;
        row.request = r;
        row.value = value;
        row.typed = typed;
        row.typed_res = e;
        stim_rows.insert(stim_rows.size(), row);
    endfunction

    // Random load: mostly a well-conditioned model near a random color, else raw bits.
    function automatic mcc_req_t random_load();
        mcc_req_t r;
        r = mcc_req_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        r.mode = MODE_LOAD;
        if ($urandom_range(0, 9) < 7) begin
            r.inv_uu_in = $urandom_range(1 << 20, 1 << 26);
            r.inv_vv_in = $urandom_range(1 << 20, 1 << 26);
            r.inv_uv_in = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        end
        return r;
    endfunction

    // Random pixel: mostly close to the mean of some class, else anywhere.
    function automatic mcc_req_t random_pixel();
        mcc_req_t r;
        int k;
        int u;
        int v;
        r = mcc_req_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        r.mode = MODE_PIXEL;
        r.last_pixel = ($urandom_range(0, 15) == 0);
        if ($urandom_range(0, 99) < 85) begin
            k = $urandom_range(0, 7);
            u = int'(sh_mean_u[k] >> 8) + $urandom_range(0, 6) - 3;
            v = int'(sh_mean_v[k] >> 8) + $urandom_range(0, 6) - 3;
            r.chroma_u = (u < 0) ? 8'd0 : (u > 255) ? 8'd255 : u[7:0];
            r.chroma_v = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
        end
        return r;
    endfunction

    // Offers one request after a random gap and returns once it is taken.
    task automatic send(mcc_req_t r);
        int gap;
        mcc_res_t o;
        gap = $urandom_range(0, idle_max);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        if (classify(r, o))
            pending_res.insert(pending_res.size(), o);
    endtask

    // Sender pauses until every result is out and any trailing load has settled.
    task automatic drain();
        req_valid <= 1'b0;
        while (pending_res.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic reg_index, logic [31:0] value);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (reg_index == REG_THETA)
            sh_theta = value;
        else
            sh_active = value[3:0];
    endtask

    task automatic mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0h, got %0h", what, exp_v, got_v);
    endtask

    // Result side: random stalls, one long hold-off on request, and the checks.
    initial begin
        int stall;
        mcc_res_t e;
        res_ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            stall = hold_req ? 300 : $urandom_range(0, idle_max);
            hold_req = 0;
            if (stall > 0) begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ready <= 1'b1;
            @(posedge clk);
            while (!res_valid)
                @(posedge clk);
            if (pending_res.size() == 0) begin
                mismatch("unexpected result", 32'd0, 32'(res));
            end else begin
                e = pending_res.pop_front();
                if (res.member_mask !== e.member_mask)
                    mismatch("member_mask", 32'(e.member_mask), 32'(res.member_mask));
                if (res.decision_valid !== e.decision_valid)
                    mismatch("decision_valid", 32'(e.decision_valid),
                             32'(res.decision_valid));
                if (res.class_found !== e.class_found)
                    mismatch("class_found", 32'(e.class_found), 32'(res.class_found));
                if (res.class_index !== e.class_index)
                    mismatch("class_index", 32'(e.class_index), 32'(res.class_index));
                if (res.winning_count !== e.winning_count)
                    mismatch("winning_count", 32'(e.winning_count),
                             32'(res.winning_count));
            end
        end
    end

    initial begin
        mcc_res_t none;
        mcc_res_t closed;
        mcc_res_t o;
        logic [31:0] theta_pick;
        logic [3:0]  active_pick;
        clk = 1'b0;
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        mismatches = 0;
        hold_req = 0;
        idle_max = 12;
        sh_theta = THETA_RESET;
        sh_active = '0;
        for (int k = 0; k < 8; k++)
            sh_count[k] = '0;
        none = '0;
        closed = '0;
        closed.decision_valid = 1'b1;

        // With no active classes a pixel matches nothing and a cluster has no winner.
        add_row(ROW_REQUEST, pixel_req(8'h80, 8'h80, 1'b1), 0, 1, closed);
        add_row(ROW_REQUEST, pixel_req(8'hFF, 8'h00, 1'b0), 0, 1, none);
        add_row(ROW_REQUEST, pixel_req(8'h00, 8'hFF, 1'b1), 0, 1, closed);
        // Every slot gets a model: identity, extreme entries, a near-zero
        // determinant, an indefinite matrix and an all-zero matrix.
        add_row(ROW_REQUEST, load_req(0, 16'h8000, 16'h8000, 1 << 24, 0, 1 << 24), 0, 0, none);
        add_row(ROW_REQUEST, load_req(1, 16'h0000, 16'h0000, 32'h7FFFFFFF, 32'h80000000,
                                      32'h7FFFFFFF), 0, 0, none);
        add_row(ROW_REQUEST, load_req(2, 16'hFFFF, 16'hFFFF, 32'h80000000, 32'h7FFFFFFF,
                                      32'h80000000), 0, 0, none);
        add_row(ROW_REQUEST, load_req(3, 16'h4000, 16'h4000, 5305, 0, 5305), 0, 0, none);
        add_row(ROW_REQUEST, load_req(4, 16'h6000, 16'hA000, 1 << 24, 0, -(1 << 24)), 0, 0, none);
        add_row(ROW_REQUEST, load_req(5, 16'h4080, 16'hC040, 1 << 22, 1 << 21, 1 << 22),
                0, 0, none);
        add_row(ROW_REQUEST, load_req(6, 16'h1234, 16'hABCD, 0, 0, 0), 0, 0, none);
        add_row(ROW_REQUEST, load_req(7, 16'h00FF, 16'hFF00, 1 << 26, -(1 << 24), 1 << 25),
                0, 0, none);
        add_row(ROW_THETA, '0, 32'hFFFFFFFF, 0, none);
        add_row(ROW_ACTIVE, '0, 8, 0, none);
        add_row(ROW_REQUEST, pixel_req(8'h80, 8'h80, 1'b0), 0, 0, none);
        add_row(ROW_REQUEST, pixel_req(8'h00, 8'h00, 1'b0), 0, 0, none);
        add_row(ROW_REQUEST, pixel_req(8'hFF, 8'hFF, 1'b0), 0, 0, none);
        add_row(ROW_REQUEST, pixel_req(8'h60, 8'hA8, 1'b0), 0, 0, none);
        add_row(ROW_REQUEST, pixel_req(8'h40, 8'h40, 1'b1), 0, 0, none);
        // A threshold of zero admits nothing; active_classes beyond the slot count.
        add_row(ROW_THETA, '0, 0, 0, none);
        add_row(ROW_ACTIVE, '0, 15, 0, none);
        add_row(ROW_REQUEST, pixel_req(8'h80, 8'h80, 1'b1), 0, 1, closed);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i]) begin
            case (stim_rows[i].kind)
                ROW_THETA:  write_reg(REG_THETA, stim_rows[i].value);
                ROW_ACTIVE: write_reg(REG_ACTIVE, stim_rows[i].value);
                default:
                begin
                    if (stim_rows[i].typed) begin
                        // Typed rows still go through the shadow to keep its counts.
                        void'(classify(stim_rows[i].request, o));
                        send_typed(stim_rows[i].request, stim_rows[i].typed_res);
                    end else begin
                        send(stim_rows[i].request);
                    end
                end
            endcase
        end

        // Random phases, each under its own register setting and idling.
        for (int ph = 0; ph < 10; ph++) begin
            case (ph % 5)
                0: theta_pick = THETA_RESET;
                1: theta_pick = $urandom;
                2: theta_pick = 32'hFFFFFFFF;
                3: theta_pick = $urandom_range(1 << 20, 1 << 28);
                default: theta_pick = (ph == 4) ? 32'd0 : $urandom_range(1 << 22, 1 << 27);
            endcase
            case (ph % 4)
                0: active_pick = 4'd8;
                1: active_pick = $urandom_range(0, 15);
                2: active_pick = 4'd15;
                default: active_pick = $urandom_range(1, 7);
            endcase
            write_reg(REG_THETA, theta_pick);
            write_reg(REG_ACTIVE, active_pick);
            idle_max = (ph % 3 == 1) ? 0 : 12;
            for (int i = 0; i < 190; i++) begin
                if (ph == 2 && i == 60)
                    hold_req = 1;
                if (ph == 6 && i == 95)
                    drain();
                if ($urandom_range(0, 9) == 0)
                    send(random_load());
                else
                    send(random_pixel());
            end
        end

        // One long back-to-back cluster on a single class builds up a large count.
        write_reg(REG_THETA, THETA_RESET);
        write_reg(REG_ACTIVE, 1);
        idle_max = 0;
        send(load_req(0, 16'h8000, 16'h8000, 1 << 24, 0, 1 << 24));
        for (int i = 0; i < LONG_PIXELS; i++)
            send(pixel_req(8'h80, 8'h80, i == LONG_PIXELS - 1));

        drain();
        if (pending_res.size() != 0)
            mismatch("results left over", 0, pending_res.size());
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Sends a request whose result was written down by hand in the table.
    task automatic send_typed(mcc_req_t r, mcc_res_t e);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        pending_res.insert(pending_res.size(), e);
    endtask

endmodule

@@ files.f @@
+incdir+sv
sv/mcc_pkg.sv
sv/mcc_weight.sv
sv/mcc_cell.sv
sv/mahalanobis_chroma_classifier.sv
tb/tb_mahalanobis_chroma_classifier.sv
